/* hdl/lsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants of the latest free slot allocator
// Request codes, command and result records, and the fixed field widths.
// ----------------------------------------------------------------------------
package lsa_pkg;

	// Fixed field widths
	localparam int VALUE_W = 10;
	localparam int STATUS_W = 2;

	// Default slot count and the most slots a 10-bit value can reach
	localparam int SLOTS_DEF = 1024;
	localparam int SLOT_CAP = 1024;

	// Reset value of the limit register
	localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 10'h3FF;

	// Occupancy row geometry
	localparam int ROW_W = 32;
	localparam int ROW_BITS = $clog2(ROW_W);

	// Queue depth between the parts
	localparam int FIFO_DEPTH = 2;

	// Request type codes
	localparam logic REQ_PLACE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_NOFREE = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_PLACE = 2'd0,
		CMD_READ = 2'd1,
		CMD_RANGE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [VALUE_W-1:0] addr;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic [VALUE_W-1:0] position;
		logic [VALUE_W-1:0] read_value;
		logic read_occupied;
	} res_t;

endpackage

/* hdl/lsa_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_fifo: short register queue
// Decouples two parts of the allocator; push and pop may happen together.
// ----------------------------------------------------------------------------
module lsa_fifo #(
	parameter int W = 12,
	parameter int DEPTH = lsa_pkg::FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [W-1:0] rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Advance pointers and count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold the entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hdl/lsa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_front: request intake and classification
// Holds the limit register, checks each request against the effective
// limit and hands a classified command to the command queue.
// ----------------------------------------------------------------------------
module lsa_front #(
	parameter int SLOTS = lsa_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [lsa_pkg::VALUE_W-1:0] cfg_wr_data,
	input logic req_type,
	input logic [lsa_pkg::VALUE_W-1:0] value,
	input logic [lsa_pkg::VALUE_W-1:0] slot_index,
	output lsa_pkg::cmd_t cmd
);

	localparam int USED = (SLOTS < lsa_pkg::SLOT_CAP) ? SLOTS : lsa_pkg::SLOT_CAP;
	localparam logic [lsa_pkg::VALUE_W-1:0] LIM_CAP = lsa_pkg::VALUE_W'(USED - 1);

	logic [lsa_pkg::VALUE_W-1:0] max_value_q;
	logic [lsa_pkg::VALUE_W-1:0] lim;
	logic [lsa_pkg::VALUE_W-1:0] addr;

	// Hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= lsa_pkg::MAX_VALUE_RST;
		end else if (cfg_wr_en) begin
			max_value_q <= cfg_wr_data;
		end
	end

	// Clamp the limit to the slots that exist
	assign lim = (max_value_q < LIM_CAP) ? max_value_q : LIM_CAP;

	// Classify the request
	assign addr = (req_type == lsa_pkg::REQ_READ) ? slot_index : value;

	always_comb begin
		cmd.addr = addr;
		if (addr > lim) begin
			cmd.kind = lsa_pkg::CMD_RANGE;
		end else if (req_type == lsa_pkg::REQ_READ) begin
			cmd.kind = lsa_pkg::CMD_READ;
		end else begin
			cmd.kind = lsa_pkg::CMD_PLACE;
		end
	end

endmodule

/* hdl/lsa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_back: slot search and update sequencer
// Occupancy lives in rows of 32 flags with a full flag per row. A place
// looks in the row of its value first, then in the highest non-full row
// below, and writes the chosen flag and the stored value back.
// ----------------------------------------------------------------------------
module lsa_back #(
	parameter int SLOTS = lsa_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input lsa_pkg::cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	input logic res_full,
	output logic res_push,
	output lsa_pkg::res_t res
);

	localparam int USED = (SLOTS < lsa_pkg::SLOT_CAP) ? SLOTS : lsa_pkg::SLOT_CAP;
	localparam int SB = (USED > 1) ? $clog2(USED) : 1;
	localparam int ROW_W = lsa_pkg::ROW_W;
	localparam int RBITS = lsa_pkg::ROW_BITS;
	localparam int NR = (USED + ROW_W - 1) / ROW_W;
	localparam int RB = (NR > 1) ? $clog2(NR) : 1;
	localparam int VW = lsa_pkg::VALUE_W;
	localparam int HIW = VW - RBITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LEAF,
		S_ALT,
		S_READ
	} state_t;

	// Highest set bit of a row, with a found flag on top
	function automatic logic [RBITS:0] top_bit(input logic [ROW_W-1:0] v);
		logic [RBITS:0] r;
		r = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (v[i]) begin
				r = {1'b1, RBITS'(i)};
			end
		end
		return r;
	endfunction

	state_t state_q;
	logic [NR-1:0] row_vld_q;
	logic [NR-1:0] full_q;
	logic [VW-1:0] addr_q;
	logic [RB-1:0] cur_row_q;
	logic [RB-1:0] alt_row_q;
	logic alt_ok_q;

	logic [ROW_W-1:0] leaf_mem [NR];
	logic [VW-1:0] val_mem [USED];
	logic [ROW_W-1:0] leaf_rd_q;
	logic [VW-1:0] val_rd_q;

	logic [HIW-1:0] cmd_hi;
	logic [RB-1:0] cmd_row;
	logic [RB-1:0] alt_row;
	logic alt_ok;
	logic [RB-1:0] rd_row;
	logic [ROW_W-1:0] row_data;
	logic [ROW_W-1:0] mask_le;
	logic [ROW_W-1:0] free_vec;
	logic [RBITS:0] hit_info;
	logic hit;
	logic [RBITS-1:0] hit_bit;
	logic [ROW_W-1:0] new_row;
	logic [VW-1:0] pos;
	logic occ;
	logic commit;
	logic go_alt;

	// Row of the incoming command
	assign cmd_hi = cmd.addr[VW-1:RBITS];
	assign cmd_row = cmd_hi[RB-1:0];

	// Find the highest row below the command's row that still has room
	always_comb begin
		alt_ok = 1'b0;
		alt_row = '0;
		for (int i = 0; i < NR; i++) begin
			if (RB'(i) < cmd_row && !full_q[i]) begin
				alt_ok = 1'b1;
				alt_row = RB'(i);
			end
		end
	end

	// Row read address: own row on intake, the fallback row afterwards
	assign rd_row = (state_q == S_IDLE) ? cmd_row : alt_row_q;

	// Row contents; a row never written reads as all free
	assign row_data = row_vld_q[cur_row_q] ? leaf_rd_q : '0;

	// Search the row, limited to bits at or below the value in its own row
	assign mask_le = {ROW_W{1'b1}} >> (RBITS'(ROW_W - 1) - addr_q[RBITS-1:0]);
	assign free_vec = ~row_data & ((state_q == S_LEAF) ? mask_le : {ROW_W{1'b1}});
	assign hit_info = top_bit(free_vec);
	assign hit = hit_info[RBITS];
	assign hit_bit = hit_info[RBITS-1:0];
	assign new_row = row_data | (ROW_W'(1) << hit_bit);
	assign pos = VW'({cur_row_q, hit_bit});
	assign occ = row_data[addr_q[RBITS-1:0]];

	// Drive handshakes and build the result
	always_comb begin
		cmd_pop = 1'b0;
		res_push = 1'b0;
		commit = 1'b0;
		go_alt = 1'b0;
		res.status = lsa_pkg::ST_OK;
		res.position = '0;
		res.read_value = '0;
		res.read_occupied = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.kind == lsa_pkg::CMD_RANGE) begin
						res_push = 1'b1;
						res.status = lsa_pkg::ST_RANGE;
					end
				end
			end
			S_LEAF: begin
				if (hit) begin
					commit = 1'b1;
				end else if (alt_ok_q) begin
					go_alt = 1'b1;
				end else begin
					res_push = 1'b1;
					res.status = lsa_pkg::ST_NOFREE;
				end
			end
			S_ALT: begin
				commit = 1'b1;
			end
			S_READ: begin
				res_push = 1'b1;
				res.read_occupied = occ;
				res.read_value = occ ? val_rd_q : '0;
			end
			default: ;
		endcase
		if (commit) begin
			res_push = 1'b1;
			res.position = pos;
		end
	end

	// Advance the sequencer and keep row flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_vld_q <= '0;
			full_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							lsa_pkg::CMD_PLACE: state_q <= S_LEAF;
							lsa_pkg::CMD_READ: state_q <= S_READ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LEAF: state_q <= go_alt ? S_ALT : S_IDLE;
				S_ALT: state_q <= S_IDLE;
				S_READ: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				row_vld_q[cur_row_q] <= 1'b1;
				full_q[cur_row_q] <= &new_row;
			end
		end
	end

	// Capture the command on intake; switch to the fallback row
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			addr_q <= cmd.addr;
			cur_row_q <= cmd_row;
			alt_row_q <= alt_row;
			alt_ok_q <= alt_ok;
		end else if (go_alt) begin
			cur_row_q <= alt_row_q;
		end
	end

	// Occupancy row memory
	always_ff @(posedge clk) begin
		if (commit) begin
			leaf_mem[cur_row_q] <= new_row;
		end
		leaf_rd_q <= leaf_mem[rd_row];
	end

	// Stored value memory
	always_ff @(posedge clk) begin
		if (commit) begin
			val_mem[pos[SB-1:0]] <= addr_q;
		end
		val_rd_q <= val_mem[cmd.addr[SB-1:0]];
	end

endmodule

/* hdl/latest_free_slot_allocator_top.sv */
`timescale 1ns / 1ps
// Flow: the back sequencer answers an out-of-range request on intake, a read in
// its read state, a place in its row search state and, on a fall back to a lower
// row, in its fallback state. Busy with the row read-modify-write, it takes a
// new request only when idle with room in the result queue. Reset (arst_n low,
// async) empties both queues, marks every slot free and sets the limit to 1023.
// ----------------------------------------------------------------------------
// latest_free_slot_allocator_top: latest free slot allocator
// Places each value in the highest free slot at or below it and answers
// slot reads; a front part and a back part joined by a command queue.
// ----------------------------------------------------------------------------
module latest_free_slot_allocator_top #(
	parameter int SLOTS = lsa_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [lsa_pkg::VALUE_W-1:0] cfg_wr_data,
	input logic push,
	output logic full,
	input logic req_type,
	input logic [lsa_pkg::VALUE_W-1:0] value,
	input logic [lsa_pkg::VALUE_W-1:0] slot_index,
	output logic empty,
	input logic pop,
	output logic [lsa_pkg::STATUS_W-1:0] status,
	output logic [lsa_pkg::VALUE_W-1:0] position,
	output logic [lsa_pkg::VALUE_W-1:0] read_value,
	output logic read_occupied
);

	lsa_pkg::cmd_t cmd_in;
	lsa_pkg::cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;
	lsa_pkg::res_t res_in;
	lsa_pkg::res_t res_head;
	logic res_push;
	logic res_full;

	// Classify requests
	lsa_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_type(req_type),
		.value(value),
		.slot_index(slot_index),
		.cmd(cmd_in)
	);

	// Queue commands between the parts
	lsa_fifo #(
		.W($bits(lsa_pkg::cmd_t)),
		.DEPTH(lsa_pkg::FIFO_DEPTH)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(cmd_in),
		.full(full),
		.pop(cmd_pop),
		.rdata(cmd_head),
		.empty(cmd_empty)
	);

	// Search and update
	lsa_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_head),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	// Queue results for the consumer
	lsa_fifo #(
		.W($bits(lsa_pkg::res_t)),
		.DEPTH(lsa_pkg::FIFO_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_head),
		.empty(empty)
	);

	assign status = res_head.status;
	assign position = res_head.position;
	assign read_value = res_head.read_value;
	assign read_occupied = res_head.read_occupied;

endmodule
